### hw/rtl/rpa_pkg.sv
// rpa_pkg: shared types, constants and the CORDIC arctangent table for the
// point-about-axis rotation pipeline. Used by every rpa_* module except rpa_delay.
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

  // default CORDIC depth and fixed pipeline latencies
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int AXIS_LAT          = 70;
  localparam int ROT_LAT           = 7;

  // angle constants, Q3.28
  localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
  localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
  localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;

  // Q2.30 constants
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;

  // unit axis word handed from the axis unit to the rotation unit
  typedef struct packed {
    logic   vld;
    logic   zero;
    coord_t ux;
    coord_t uy;
    coord_t uz;
  } axis_res_t;

  // rounded atan(2^-i) in Q2.30
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      24: v = 32'd64;
      25: v = 32'd32;
      26: v = 32'd16;
      27: v = 32'd8;
      28: v = 32'd4;
      29: v = 32'd2;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rpa_delay.sv
// rpa_delay: fixed-depth shift line that keeps side data aligned with the
// axis pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpa_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // shift line
  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int k = 1; k < DEPTH; k++) begin
      tap_r[k] <= tap_r[k-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

`default_nettype wire

### hw/rtl/rpa_axis.sv
// rpa_axis: axis direction to Q2.30 unit vector: block scaling, squares,
// bit-per-stage square root and bit-per-stage division. Uses rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpa_axis
  import rpa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_vld,
  input  wire diff_t r_x,
  input  wire diff_t r_y,
  input  wire diff_t r_z,
  output axis_res_t  res
);

  diff_t r_in [3];
  assign r_in[0] = r_x;
  assign r_in[1] = r_y;
  assign r_in[2] = r_z;

  // ---- stage A: magnitudes, signs, leading one of the largest
  logic [31:0] abs_nxt [3];
  logic [31:0] big;
  logic [4:0]  msb_nxt;
  logic [31:0] mabs_r [3];
  logic [4:0]  msb_r;
  logic [2:0]  sgn_a_r;
  logic        zero_a_r, vld_a_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_nxt[i] = r_in[i][32] ? 32'(-r_in[i]) : r_in[i][31:0];
    end
    big = abs_nxt[0];
    if (abs_nxt[1] > big) big = abs_nxt[1];
    if (abs_nxt[2] > big) big = abs_nxt[2];
    msb_nxt = '0;
    for (int b = 0; b < 32; b++) begin
      if (big[b]) msb_nxt = 5'(b);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mabs_r[i]  <= abs_nxt[i];
      sgn_a_r[i] <= r_in[i][32];
    end
    msb_r    <= msb_nxt;
    zero_a_r <= (big == '0);
  end

  // ---- stage B: scale so the largest lies in [2^29, 2^30)
  logic [29:0] m_nxt [3];
  logic [29:0] m_b_r [3];
  logic [2:0]  sgn_b_r;
  logic        zero_b_r, vld_b_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (msb_r >= 5'd29) m_nxt[i] = 30'(mabs_r[i] >> (msb_r - 5'd29));
      else                m_nxt[i] = 30'({30'b0, mabs_r[i]} << (5'd29 - msb_r));
    end
  end

  always_ff @(posedge clk) begin
    m_b_r    <= m_nxt;
    sgn_b_r  <= sgn_a_r;
    zero_b_r <= zero_a_r;
  end

  // ---- stage C: squares
  logic [59:0] sq_c_r [3];
  logic [29:0] m_c_r [3];
  logic [2:0]  sgn_c_r;
  logic        zero_c_r, vld_c_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_c_r[i] <= m_b_r[i] * m_b_r[i];
    end
    m_c_r    <= m_b_r;
    sgn_c_r  <= sgn_b_r;
    zero_c_r <= zero_b_r;
  end

  // ---- stage D: sum of squares; feeds the root pipeline (index 0)
  logic [63:0] sv_r  [0:32];
  logic [63:0] sr_r  [0:32];
  logic [29:0] sm_r  [0:32][3];
  logic [2:0]  ss_r  [0:32];
  logic        sz_r  [0:32];
  logic        svl_r [0:32];

  always_ff @(posedge clk) begin
    sv_r[0]  <= 64'(sq_c_r[0]) + 64'(sq_c_r[1]) + 64'(sq_c_r[2]);
    sr_r[0]  <= '0;
    sm_r[0]  <= m_c_r;
    ss_r[0]  <= sgn_c_r;
    sz_r[0]  <= zero_c_r;
  end

  // ---- square root, one result bit per stage
  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sr_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (sv_r[k] >= trial) begin
        sv_r[k+1] <= sv_r[k] - trial;
        sr_r[k+1] <= (sr_r[k] >> 1) + BIT;
      end else begin
        sv_r[k+1] <= sv_r[k];
        sr_r[k+1] <= sr_r[k] >> 1;
      end
      sm_r[k+1] <= sm_r[k];
      ss_r[k+1] <= ss_r[k];
      sz_r[k+1] <= sz_r[k];
    end
  end

  // ---- stage E: rounded dividends; feeds the divider (index 0)
  logic [63:0] dn_r  [0:32][3];
  logic [31:0] dq_r  [0:32][3];
  logic [31:0] dd_r  [0:32];
  logic [2:0]  ds_r  [0:32];
  logic        dz_r  [0:32];
  logic        dvl_r [0:32];
  logic [31:0] mag;

  assign mag = sr_r[32][31:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dn_r[0][i] <= {4'b0, sm_r[32][i], 30'b0} + 64'(mag >> 1);
      dq_r[0][i] <= '0;
    end
    dd_r[0] <= mag;
    ds_r[0] <= ss_r[32];
    dz_r[0] <= sz_r[32];
  end

  // ---- restoring division, one quotient bit per stage
  for (genvar k = 0; k < 32; k++) begin : g_div
    logic [63:0] dsh;
    assign dsh = {32'b0, dd_r[k]} << (31 - k);
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (dn_r[k][i] >= dsh) begin
          dn_r[k+1][i] <= dn_r[k][i] - dsh;
          dq_r[k+1][i] <= {dq_r[k][i][30:0], 1'b1};
        end else begin
          dn_r[k+1][i] <= dn_r[k][i];
          dq_r[k+1][i] <= {dq_r[k][i][30:0], 1'b0};
        end
      end
      dd_r[k+1] <= dd_r[k];
      ds_r[k+1] <= ds_r[k];
      dz_r[k+1] <= dz_r[k];
    end
  end

  // ---- stage F: apply signs, zero axis gives a zero vector
  coord_t u_r [3];
  logic   zero_f_r, vld_f_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dz_r[32])         u_r[i] <= '0;
      else if (ds_r[32][i]) u_r[i] <= -$signed(dq_r[32][i]);
      else                  u_r[i] <= $signed(dq_r[32][i]);
    end
    zero_f_r <= dz_r[32];
  end

  // ---- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_f_r <= 1'b0;
      for (int k = 0; k <= 32; k++) begin
        svl_r[k] <= 1'b0;
        dvl_r[k] <= 1'b0;
      end
    end else begin
      vld_a_r  <= in_vld;
      vld_b_r  <= vld_a_r;
      vld_c_r  <= vld_b_r;
      svl_r[0] <= vld_c_r;
      for (int k = 0; k < 32; k++) begin
        svl_r[k+1] <= svl_r[k];
        dvl_r[k+1] <= dvl_r[k];
      end
      dvl_r[0] <= svl_r[32];
      vld_f_r  <= dvl_r[32];
    end
  end

  assign res.vld  = vld_f_r;
  assign res.zero = zero_f_r;
  assign res.ux   = u_r[0];
  assign res.uy   = u_r[1];
  assign res.uz   = u_r[2];

endmodule

`default_nettype wire

### hw/rtl/rpa_cordic.sv
// rpa_cordic: angle reduction and pipelined rotation-mode CORDIC giving
// cos and sin in Q2.30. Uses rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpa_cordic
  import rpa_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic   clk,
  input  wire coord_t angle,
  output coord_t      cos_q,
  output coord_t      sin_q
);

  logic signed [33:0] x_r [0:STAGES];
  logic signed [33:0] y_r [0:STAGES];
  logic signed [35:0] z_r [0:STAGES];
  logic               neg_r [0:STAGES];

  // ---- reduce to [-pi, pi], then fold into [-pi/2, pi/2]
  logic signed [32:0] red, fold;
  logic               neg_nxt;

  always_comb begin
    red = 33'(angle);
    if (red > PI_Q28)       red = red - TWO_PI_Q28;
    else if (red < -PI_Q28) red = red + TWO_PI_Q28;
    neg_nxt = 1'b1;
    if (red > HALF_PI_Q28)       fold = red - PI_Q28;
    else if (red < -HALF_PI_Q28) fold = red + PI_Q28;
    else begin
      fold    = red;
      neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= CORDIC_K;
    y_r[0]   <= '0;
    z_r[0]   <= 36'($signed({fold, 2'b00}));
    neg_r[0] <= neg_nxt;
  end

  // ---- one micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [35:0] at;
    assign at = $signed({4'b0, atan_q30(i)});
    always_ff @(posedge clk) begin
      if (!z_r[i][35]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - at;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + at;
      end
      neg_r[i+1] <= neg_r[i];
    end
  end

  // ---- clamp to [-1, 1] and undo the fold
  logic signed [33:0] xc, yc;
  coord_t cos_r, sin_r;

  always_comb begin
    xc = x_r[STAGES];
    yc = y_r[STAGES];
    if (xc > 34'(ONE_Q30))  xc = 34'(ONE_Q30);
    if (xc < -34'(ONE_Q30)) xc = -34'(ONE_Q30);
    if (yc > 34'(ONE_Q30))  yc = 34'(ONE_Q30);
    if (yc < -34'(ONE_Q30)) yc = -34'(ONE_Q30);
  end

  always_ff @(posedge clk) begin
    cos_r <= neg_r[STAGES] ? 32'(-xc) : 32'(xc);
    sin_r <= neg_r[STAGES] ? 32'(-yc) : 32'(yc);
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

`default_nettype wire

### hw/rtl/rpa_rotate.sv
// rpa_rotate: builds the axis-angle matrix from u, cos, sin and applies it to
// P - A, with rounding and saturation. Uses rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpa_rotate
  import rpa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire axis_res_t axis,
  input  wire coord_t    cos_q,
  input  wire coord_t    sin_q,
  input  wire diff_t     d_in [3],
  input  wire coord_t    a_in [3],
  output logic           out_vld,
  output coord_t         out_pt [3],
  output logic           out_zero,
  output logic           out_ovf
);

  logic [ROT_LAT-1:0] vld_r;
  logic               zero_r [ROT_LAT];
  diff_t              d_r [4][3];
  coord_t             a_r [6][3];
  coord_t             u_r [2][3];
  coord_t             c_r [3];

  coord_t u_in [3];
  assign u_in[0] = axis.ux;
  assign u_in[1] = axis.uy;
  assign u_in[2] = axis.uz;

  // side data carried along the stages
  always_ff @(posedge clk) begin
    zero_r[0] <= axis.zero;
    d_r[0]    <= d_in;
    a_r[0]    <= a_in;
    u_r[0]    <= u_in;
    c_r[0]    <= cos_q;
    for (int k = 1; k < ROT_LAT; k++) zero_r[k] <= zero_r[k-1];
    for (int k = 1; k < 6; k++) a_r[k] <= a_r[k-1];
    for (int k = 1; k < 4; k++) d_r[k] <= d_r[k-1];
    for (int k = 1; k < 2; k++) u_r[k] <= u_r[k-1];
    for (int k = 1; k < 3; k++) c_r[k] <= c_r[k-1];
  end

  // ---- M1: (1-c)*u and u*s products
  logic signed [32:0] t;
  logic signed [64:0] ptu_r [3];
  logic signed [64:0] pus_r [3];

  assign t = ONE_Q30 - 33'(cos_q);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ptu_r[i] <= t * u_in[i];
      pus_r[i] <= 65'(u_in[i]) * 65'(sin_q);
    end
  end

  // ---- M2: round both to Q2.30
  logic signed [64:0] rtu [3], rus [3];
  logic signed [34:0] tu_r [3];
  logic signed [34:0] su_r [3][2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rtu[i] = (ptu_r[i] + 65'sd536870912) >>> 30;
      rus[i] = (pus_r[i] + 65'sd536870912) >>> 30;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tu_r[i]    <= 35'(rtu[i]);
      su_r[i][0] <= 35'(rus[i]);
      su_r[i][1] <= su_r[i][0];
    end
  end

  // ---- M3: outer product terms
  logic signed [66:0] pp_r [3][3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp_r[i][j] <= 67'(tu_r[i]) * 67'(u_r[1][j]);
      end
    end
  end

  // ---- M4: matrix entries with diagonal and skew terms, clamped
  logic signed [66:0] rp;
  logic signed [39:0] me [3][3];
  coord_t             mm_r [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rp       = (pp_r[i][j] + 67'sd536870912) >>> 30;
        me[i][j] = 40'(rp);
        if (i == j) me[i][j] = me[i][j] + 40'(c_r[2]);
      end
    end
    me[0][1] = me[0][1] - 40'(su_r[2][1]);
    me[1][0] = me[1][0] + 40'(su_r[2][1]);
    me[0][2] = me[0][2] + 40'(su_r[1][1]);
    me[2][0] = me[2][0] - 40'(su_r[1][1]);
    me[1][2] = me[1][2] - 40'(su_r[0][1]);
    me[2][1] = me[2][1] + 40'(su_r[0][1]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (me[i][j] > 40'(ONE_Q30))  me[i][j] = 40'(ONE_Q30);
        if (me[i][j] < -40'(ONE_Q30)) me[i][j] = -40'(ONE_Q30);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mm_r[i][j] <= 32'(me[i][j]);
      end
    end
  end

  // ---- M5: matrix times offset
  logic signed [64:0] pr_r [3][3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr_r[i][j] <= 65'(mm_r[i][j]) * 65'(d_r[3][j]);
      end
    end
  end

  // ---- M6: row sums of quarter products
  logic signed [65:0] acc_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      acc_r[i] <= 66'(pr_r[i][0] >>> 2) + 66'(pr_r[i][1] >>> 2) + 66'(pr_r[i][2] >>> 2);
    end
  end

  // ---- M7: round to Q16.16, add A back, saturate
  logic signed [65:0] q [3];
  logic [2:0]         sat;
  coord_t             pt_nxt [3];
  coord_t             pt_r [3];
  logic               ovf_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = ((acc_r[i] + 66'sd134217728) >>> 28) + 66'(a_r[5][i]);
      sat[i] = 1'b1;
      if (q[i] > 66'sd2147483647)       pt_nxt[i] = 32'sh7fffffff;
      else if (q[i] < -66'sd2147483648) pt_nxt[i] = 32'sh80000000;
      else begin
        pt_nxt[i] = 32'(q[i]);
        sat[i]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pt_r  <= pt_nxt;
    ovf_r <= |sat;
  end

  // ---- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[ROT_LAT-2:0], axis.vld};
  end

  assign out_vld  = vld_r[ROT_LAT-1];
  assign out_pt   = pt_r;
  assign out_zero = zero_r[ROT_LAT-1];
  assign out_ovf  = ovf_r;

endmodule

`default_nettype wire

### hw/rtl/rotate_point_about_axis.sv
// rotate_point_about_axis: top level of the point-about-axis rotation pipeline.
// Depends on rpa_pkg, rpa_axis, rpa_cordic, rpa_delay and rpa_rotate.
//
// Usage:
//   Input channel: drive the point, the two axis points and the angle on the
//   in_* ports and raise start. A word is taken at each rising edge with
//   start high and busy low; busy is always low, so one word per cycle.
//   Result channel: out_valid is high for exactly one cycle with the rotated
//   point and the zero_axis and overflow flags on the out_* ports.
//   Path: the accepted word passes through the axis unit (scaling and squares,
//   32-step square root, 32-step divider, 70 stages), then through the
//   7-stage matrix unit.
//   Throughput: one word per cycle, results in input order.
//   The CORDIC (input register, CORDIC_STAGES micro-rotations, output register)
//   runs beside the axis unit, padded by a shift line to the axis latency.
//   Reset: rst_n low synchronously clears all valid bits; words in flight are
//   dropped and no result appears until new words arrive.
//   The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
`default_nettype none

module rotate_point_about_axis
  import rpa_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire coord_t in_point_x,
  input  wire coord_t in_point_y,
  input  wire coord_t in_point_z,
  input  wire coord_t in_axis_a_x,
  input  wire coord_t in_axis_a_y,
  input  wire coord_t in_axis_a_z,
  input  wire coord_t in_axis_b_x,
  input  wire coord_t in_axis_b_y,
  input  wire coord_t in_axis_b_z,
  input  wire coord_t in_angle,
  output logic      out_valid,
  output coord_t    out_rotated_x,
  output coord_t    out_rotated_y,
  output coord_t    out_rotated_z,
  output logic      out_zero_axis,
  output logic      out_overflow
);

  localparam int CS_PAD = AXIS_LAT - (CORDIC_STAGES + 2);

  assign busy = 1'b0;

  // axis and offset vectors
  diff_t r_x, r_y, r_z;
  diff_t d_now [3];
  assign r_x = 33'(in_axis_b_x) - 33'(in_axis_a_x);
  assign r_y = 33'(in_axis_b_y) - 33'(in_axis_a_y);
  assign r_z = 33'(in_axis_b_z) - 33'(in_axis_a_z);
  assign d_now[0] = 33'(in_point_x) - 33'(in_axis_a_x);
  assign d_now[1] = 33'(in_point_y) - 33'(in_axis_a_y);
  assign d_now[2] = 33'(in_point_z) - 33'(in_axis_a_z);

  // unit axis
  axis_res_t axis;
  rpa_axis u_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start & ~busy),
    .r_x    (r_x),
    .r_y    (r_y),
    .r_z    (r_z),
    .res    (axis)
  );

  // cos and sin, padded to the axis latency
  coord_t cos_c, sin_c, cos_d, sin_d;
  rpa_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk   (clk),
    .angle (in_angle),
    .cos_q (cos_c),
    .sin_q (sin_c)
  );

  rpa_delay #(.WIDTH(64), .DEPTH(CS_PAD)) u_cs_dly (
    .clk  (clk),
    .din  ({cos_c, sin_c}),
    .dout ({cos_d, sin_d})
  );

  // offset and axis origin, delayed to meet the unit axis
  logic [194:0] side_d;
  diff_t        d_al [3];
  coord_t       a_al [3];
  rpa_delay #(.WIDTH(195), .DEPTH(AXIS_LAT)) u_side_dly (
    .clk  (clk),
    .din  ({d_now[0], d_now[1], d_now[2], in_axis_a_x, in_axis_a_y, in_axis_a_z}),
    .dout (side_d)
  );
  assign d_al[0] = side_d[194:162];
  assign d_al[1] = side_d[161:129];
  assign d_al[2] = side_d[128:96];
  assign a_al[0] = side_d[95:64];
  assign a_al[1] = side_d[63:32];
  assign a_al[2] = side_d[31:0];

  // matrix build and apply
  coord_t pt [3];
  rpa_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .axis     (axis),
    .cos_q    (cos_d),
    .sin_q    (sin_d),
    .d_in     (d_al),
    .a_in     (a_al),
    .out_vld  (out_valid),
    .out_pt   (pt),
    .out_zero (out_zero_axis),
    .out_ovf  (out_overflow)
  );

  assign out_rotated_x = pt[0];
  assign out_rotated_y = pt[1];
  assign out_rotated_z = pt[2];

endmodule

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking testbench for rotate_point_about_axis.
// Drives point/axis/angle words, predicts each rotated point with a bit-exact
// fixed-point model and compares results in order. Depends on rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

// one input word
typedef struct {
  logic signed [31:0] p[3];
  logic signed [31:0] a[3];
  logic signed [31:0] b[3];
  logic signed [31:0] ang;
} rot_word_t;

// one rotated point with flags
typedef struct {
  logic signed [31:0] r[3];
  logic zero;
  logic ovf;
} rot_res_t;

class rotation_scoreboard;
  rot_res_t pending[$];
  int mismatches;

  // floor shift right
  static function longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint rmul(longint x, longint y);
    return fshr(x * y + (64'sd1 <<< 29), 30);
  endfunction

  static function longint clamp_one(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v -= r + bit_w;
        r = (r >> 1) + bit_w;
      end else r >>= 1;
      bit_w >>= 2;
    end
    return r;
  endfunction

  // full rotation of one word
  static function rot_res_t rotate(rot_word_t w);
    longint a[3], r[3], d[3], u[3], m[3][3];
    longint unsigned mg[3], big, sq, mag;
    longint ang, x, y, z, dx, dy, c, s, t, tu, sx, sy, sz, acc, q;
    bit neg;
    rot_res_t o;
    big = 0;
    neg = 0;
    o.ovf = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = w.a[i];
      r[i] = longint'(w.b[i]) - a[i];
      d[i] = longint'(w.p[i]) - a[i];
      mg[i] = r[i] < 0 ? -r[i] : r[i];
      if (mg[i] > big) big = mg[i];
      u[i] = 0;
    end
    o.zero = (big == 0);
    if (!o.zero) begin
      while (big >= (64'd1 << 30)) begin
        big >>= 1;
        for (int i = 0; i < 3; i++) mg[i] >>= 1;
      end
      while (big < (64'd1 << 29)) begin
        big <<= 1;
        for (int i = 0; i < 3; i++) mg[i] <<= 1;
      end
      sq = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
      mag = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = ((mg[i] << 30) + (mag >> 1)) / mag;
        u[i] = r[i] < 0 ? -q : q;
      end
    end
    // angle reduction and CORDIC
    ang = w.ang;
    while (ang > 843314857) ang -= 1686629713;
    while (ang < -843314857) ang += 1686629713;
    if (ang > 421657428) begin
      ang -= 843314857;
      neg = 1;
    end else if (ang < -421657428) begin
      ang += 843314857;
      neg = 1;
    end
    x = 652032874;
    y = 0;
    z = ang * 4;
    for (int i = 0; i < 24; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= rpa_pkg::atan_q30(i);
      end else begin
        x += dx; y -= dy; z += rpa_pkg::atan_q30(i);
      end
    end
    x = clamp_one(x);
    y = clamp_one(y);
    c = neg ? -x : x;
    s = neg ? -y : y;
    t = 64'sd1073741824 - c;
    for (int i = 0; i < 3; i++) begin
      tu = rmul(t, u[i]);
      for (int j = 0; j < 3; j++) m[i][j] = rmul(tu, u[j]);
      m[i][i] += c;
    end
    sx = rmul(u[0], s);
    sy = rmul(u[1], s);
    sz = rmul(u[2], s);
    m[0][1] -= sz; m[1][0] += sz;
    m[0][2] += sy; m[2][0] -= sy;
    m[1][2] -= sx; m[2][1] += sx;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += fshr(clamp_one(m[i][j]) * d[j], 2);
      q = fshr(acc + (64'sd1 <<< 27), 28) + a[i];
      if (q > 64'sd2147483647) begin
        q = 64'sd2147483647; o.ovf = 1;
      end
      if (q < -64'sd2147483648) begin
        q = -64'sd2147483648; o.ovf = 1;
      end
      o.r[i] = q[31:0];
    end
    return o;
  endfunction

  function void note_word(rot_word_t w);
    pending.push_back(rotate(w));
  endfunction

  function void check_result(rot_res_t got);
    rot_res_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result word");
      return;
    end
    want = pending.pop_front();
    if (got.r[0] !== want.r[0] || got.r[1] !== want.r[1] || got.r[2] !== want.r[2] ||
        got.zero !== want.zero || got.ovf !== want.ovf) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: exp %0d %0d %0d z%0b o%0b got %0d %0d %0d z%0b o%0b",
                 want.r[0], want.r[1], want.r[2], want.zero, want.ovf,
                 got.r[0], got.r[1], got.r[2], got.zero, got.ovf);
    end
  endfunction
endclass

module tb_top;
  import rpa_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  coord_t in_p[3], in_a[3], in_b[3];
  coord_t in_angle;
  logic out_valid, out_zero_axis, out_overflow;
  coord_t out_rotated_x, out_rotated_y, out_rotated_z;
  rotation_scoreboard sb;

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < 3; i++) begin
      in_p[i] = 0; in_a[i] = 0; in_b[i] = 0;
    end
    in_angle = 0;
  end

  rotate_point_about_axis DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_p[0]), .in_point_y(in_p[1]), .in_point_z(in_p[2]),
    .in_axis_a_x(in_a[0]), .in_axis_a_y(in_a[1]), .in_axis_a_z(in_a[2]),
    .in_axis_b_x(in_b[0]), .in_axis_b_y(in_b[1]), .in_axis_b_z(in_b[2]),
    .in_angle(in_angle),
    .out_valid(out_valid), .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y), .out_rotated_z(out_rotated_z),
    .out_zero_axis(out_zero_axis), .out_overflow(out_overflow)
  );

  // note accepted words and check results at the rising edge
  always @(posedge clk) begin
    rot_res_t got;
    if (rst_n && start && !busy) begin
      rot_word_t w;
      w.p = in_p; w.a = in_a; w.b = in_b; w.ang = in_angle;
      sb.note_word(w);
    end
    if (rst_n && out_valid) begin
      got.r[0] = out_rotated_x; got.r[1] = out_rotated_y; got.r[2] = out_rotated_z;
      got.zero = out_zero_axis; got.ovf = out_overflow;
      sb.check_result(got);
    end
  end

  // present one word; start stays high if the next word follows at once
  task automatic send_word(rot_word_t w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    in_p <= w.p; in_a <= w.a; in_b <= w.b; in_angle <= w.ang;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    endcase
  endfunction

  function automatic rot_word_t rand_word();
    rot_word_t w;
    for (int i = 0; i < 3; i++) begin
      w.p[i] = rand_coord(); w.a[i] = rand_coord(); w.b[i] = rand_coord();
    end
    // occasional coincident axis points, or axis along one coordinate
    if ($urandom_range(0, 9) == 0) w.b = w.a;
    else if ($urandom_range(0, 9) == 0) begin
      w.b = w.a;
      w.b[$urandom_range(0, 2)] = rand_coord();
    end
    w.ang = $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 32'h7000_0000))
            - 32'sh3800_0000;
    return w;
  endfunction

  initial begin
    rot_word_t w;
    int wait_cnt;
    logic signed [31:0] angles[8];
    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: key angles about a unit z axis
    angles = '{0, 421657428, 843314857, -843314857, 843314858, 32'sh7fffffff,
               32'sh80000000, -421657429};
    foreach (angles[k]) begin
      w.p = '{32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000};
      w.a = '{0, 0, 0};
      w.b = '{0, 0, 32'sh0001_0000};
      w.ang = angles[k];
      send_word(w);
    end
    // coincident axis points
    w.p = '{32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000};
    w.a = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000};
    w.b = w.a; w.ang = 32'sh1000_0000;
    send_word(w);
    // extremes: saturating results, then offsets and axes of one LSB
    w.p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    w.a = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    w.b = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000};
    w.ang = 421657428;
    send_word(w);
    w.p = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    w.a = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    w.b = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    w.ang = 843314857;
    send_word(w);
    w.p = '{-1, -1, -1}; w.a = '{0, 0, 0}; w.b = '{-1, -1, -1}; w.ang = -1;
    send_word(w);
    w.p = '{0, 0, 0}; w.a = '{0, 0, 0}; w.b = '{1, 0, 0}; w.ang = 1;
    send_word(w);
    // random words
    repeat (500) send_word(rand_word());
    start <= 0;
    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 2000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (100) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

`default_nettype wire

### files.f
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_delay.sv
hw/rtl/rpa_axis.sv
hw/rtl/rpa_cordic.sv
hw/rtl/rpa_rotate.sv
hw/rtl/rotate_point_about_axis.sv
tb/tb_top.sv
